// ===== rtl/qvr_pkg.sv =====
// Shared types and constants for the quaternion vector rotator.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

    // Quaternion registers are signed Q2.x, always 16 bits wide.
    localparam int QUAT_W    = 16;
    // A lane coefficient is a quaternion part or its negation, so it needs one more bit.
    localparam int QCOEF_W   = QUAT_W + 1;
    localparam int CFG_IDX_W = 2;
    // Cycles from an accepted request to its result strobe.
    localparam int LATENCY   = 6;

    localparam logic signed [QUAT_W-1:0] QW_RESET = 16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        QREG_X = 2'd0,
        QREG_Y = 2'd1,
        QREG_Z = 2'd2,
        QREG_W = 2'd3
    } t_qreg;

    typedef struct packed {
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
        logic signed [QUAT_W-1:0] w;
    } t_quat;

    // Signed weights that one output lane applies to tw, tx, ty and tz.
    typedef struct packed {
        logic signed [QCOEF_W-1:0] ctw;
        logic signed [QCOEF_W-1:0] ctx;
        logic signed [QCOEF_W-1:0] cty;
        logic signed [QCOEF_W-1:0] ctz;
    } t_lane_coef;

endpackage

`default_nettype wire

// ===== rtl/qvr_tprod.sv =====
// First Hamilton product t = q * (v, 0), two pipeline stages.
// Depends on qvr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qvr_tprod
    import qvr_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  wire                                   i_clk,
    input  t_quat                                 i_quat,
    input  wire logic signed [COORD_WIDTH-1:0]    i_vx,
    input  wire logic signed [COORD_WIDTH-1:0]    i_vy,
    input  wire logic signed [COORD_WIDTH-1:0]    i_vz,
    output logic signed [QUAT_W+COORD_WIDTH+1:0]  o_tw,
    output logic signed [QUAT_W+COORD_WIDTH+1:0]  o_tx,
    output logic signed [QUAT_W+COORD_WIDTH+1:0]  o_ty,
    output logic signed [QUAT_W+COORD_WIDTH+1:0]  o_tz
);

    localparam int P_W = QUAT_W + COORD_WIDTH;
    localparam int T_W = P_W + 2;

    logic signed [P_W-1:0] r_p_wx, r_p_yz, r_p_zy;
    logic signed [P_W-1:0] r_p_wy, r_p_xz, r_p_zx;
    logic signed [P_W-1:0] r_p_wz, r_p_xy, r_p_yx;
    logic signed [P_W-1:0] r_p_xx, r_p_yy, r_p_zz;

    // Stage one: the twelve partial products.
    always_ff @(posedge i_clk) begin
        r_p_wx <= P_W'(i_quat.w) * P_W'(i_vx);
        r_p_yz <= P_W'(i_quat.y) * P_W'(i_vz);
        r_p_zy <= P_W'(i_quat.z) * P_W'(i_vy);
        r_p_wy <= P_W'(i_quat.w) * P_W'(i_vy);
        r_p_xz <= P_W'(i_quat.x) * P_W'(i_vz);
        r_p_zx <= P_W'(i_quat.z) * P_W'(i_vx);
        r_p_wz <= P_W'(i_quat.w) * P_W'(i_vz);
        r_p_xy <= P_W'(i_quat.x) * P_W'(i_vy);
        r_p_yx <= P_W'(i_quat.y) * P_W'(i_vx);
        r_p_xx <= P_W'(i_quat.x) * P_W'(i_vx);
        r_p_yy <= P_W'(i_quat.y) * P_W'(i_vy);
        r_p_zz <= P_W'(i_quat.z) * P_W'(i_vz);
    end

    // Stage two: three-term sums, two guard bits keep them exact.
    always_ff @(posedge i_clk) begin
        o_tx <= T_W'(r_p_wx) + T_W'(r_p_yz) - T_W'(r_p_zy);
        o_ty <= T_W'(r_p_wy) - T_W'(r_p_xz) + T_W'(r_p_zx);
        o_tz <= T_W'(r_p_wz) + T_W'(r_p_xy) - T_W'(r_p_yx);
        o_tw <= -T_W'(r_p_xx) - T_W'(r_p_yy) - T_W'(r_p_zz);
    end

endmodule

`default_nettype wire

// ===== rtl/qvr_lane.sv =====
// One output lane of the second Hamilton product: weighted sum, rounding, saturation.
// Depends on qvr_pkg; three copies run side by side in the top level.
`timescale 1ns / 1ps
`default_nettype none

module qvr_lane
    import qvr_pkg::*;
#(
    parameter int COORD_WIDTH    = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  wire                                        i_clk,
    input  t_lane_coef                                 i_coef,
    input  wire logic signed [QUAT_W+COORD_WIDTH+1:0]  i_tw,
    input  wire logic signed [QUAT_W+COORD_WIDTH+1:0]  i_tx,
    input  wire logic signed [QUAT_W+COORD_WIDTH+1:0]  i_ty,
    input  wire logic signed [QUAT_W+COORD_WIDTH+1:0]  i_tz,
    output logic signed [COORD_WIDTH-1:0]              o_val,
    output logic                                       o_clip
);

    localparam int T_W   = QUAT_W + COORD_WIDTH + 2;
    localparam int P2_W  = T_W + QCOEF_W;
    localparam int S_W   = P2_W + 2;
    localparam int SHIFT = 2 * QUAT_FRAC_BITS;
    localparam int RND_W = ((S_W > SHIFT + 1) ? S_W : SHIFT + 1) + 1;

    localparam logic signed [RND_W-1:0] HALF =
        {{(RND_W - SHIFT){1'b0}}, 1'b1, {(SHIFT - 1){1'b0}}};
    localparam logic signed [RND_W-1:0] MAXV =
        {{(RND_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [RND_W-1:0] MINV =
        {{(RND_W - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

    logic signed [P2_W-1:0]  r_p0, r_p1, r_p2, r_p3;
    logic signed [S_W-1:0]   r_sum;
    logic signed [RND_W-1:0] w_rnd;
    logic signed [COORD_WIDTH-1:0] n_val;
    logic                          n_clip;

    always_ff @(posedge i_clk) begin
        r_p0 <= P2_W'(i_coef.ctw) * P2_W'(i_tw);
        r_p1 <= P2_W'(i_coef.ctx) * P2_W'(i_tx);
        r_p2 <= P2_W'(i_coef.cty) * P2_W'(i_ty);
        r_p3 <= P2_W'(i_coef.ctz) * P2_W'(i_tz);
    end

    always_ff @(posedge i_clk) begin
        r_sum <= S_W'(r_p0) + S_W'(r_p1) + S_W'(r_p2) + S_W'(r_p3);
    end

    // Round half up, then clamp to the coordinate range.
    always_comb begin
        w_rnd  = (RND_W'(r_sum) + HALF) >>> SHIFT;
        n_clip = 1'b0;
        if (w_rnd > MAXV) begin
            n_val  = MAXV[COORD_WIDTH-1:0];
            n_clip = 1'b1;
        end else if (w_rnd < MINV) begin
            n_val  = MINV[COORD_WIDTH-1:0];
            n_clip = 1'b1;
        end else begin
            n_val = w_rnd[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_val  <= n_val;
        o_clip <= n_clip;
    end

endmodule

`default_nettype wire

// ===== rtl/qvr_merge.sv =====
// Output stage: joins the three lane results and their clip flags into one result.
// Depends on qvr_pkg for the shared conventions of the block.
`timescale 1ns / 1ps
`default_nettype none

module qvr_merge
    import qvr_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_vld,
    input  wire logic signed [COORD_WIDTH-1:0]  i_x,
    input  wire logic signed [COORD_WIDTH-1:0]  i_y,
    input  wire logic signed [COORD_WIDTH-1:0]  i_z,
    input  wire                                 i_clip_x,
    input  wire                                 i_clip_y,
    input  wire                                 i_clip_z,
    output logic                                o_valid,
    output logic signed [COORD_WIDTH-1:0]       o_x,
    output logic signed [COORD_WIDTH-1:0]       o_y,
    output logic signed [COORD_WIDTH-1:0]       o_z,
    output logic                                o_clipped
);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_x       <= i_x;
        o_y       <= i_y;
        o_z       <= i_z;
        o_clipped <= i_clip_x | i_clip_y | i_clip_z;
    end

endmodule

`default_nettype wire

// ===== rtl/quaternion_vector_rotate.sv =====
// Quaternion vector rotator on a 6-stage multiplier pipeline; while busy is low,
// one request can be accepted every cycle. Synchronous active-low reset restores the
// identity quaternion, empties the pipeline and holds busy high; busy drops in the cycle
// after reset is released. Results cannot be stalled: each one is presented for exactly
// one cycle.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_vector_rotate
    import qvr_pkg::*;
#(
    parameter int COORD_WIDTH    = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Request channel.
    input  wire                                 start,
    output logic                                busy,
    input  wire logic signed [COORD_WIDTH-1:0]  i_vec_in_x,
    input  wire logic signed [COORD_WIDTH-1:0]  i_vec_in_y,
    input  wire logic signed [COORD_WIDTH-1:0]  i_vec_in_z,
    // Configuration write port.
    input  wire                                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  wire logic [QUAT_W-1:0]              i_cfg_data,
    // Result channel.
    output logic                                o_valid,
    output logic signed [COORD_WIDTH-1:0]       o_vec_out_x,
    output logic signed [COORD_WIDTH-1:0]       o_vec_out_y,
    output logic signed [COORD_WIDTH-1:0]       o_vec_out_z,
    output logic                                o_clipped
);

    localparam int T_W = QUAT_W + COORD_WIDTH + 2;

    // The datapath is split as follows. Stages one and two form
    // t = q * (v, 0) in qvr_tprod. Stages three to five run in three
    // identical lanes; each lane forms one vector part of t * conj(q),
    // then rounds and saturates it. Stage six, in qvr_merge, registers
    // the three parts together and ORs their clip flags.

    t_quat                   r_quat;
    logic                    r_ready;
    logic [LATENCY-2:0]      r_vld;
    logic                    w_accept;

    logic signed [T_W-1:0]   w_tw, w_tx, w_ty, w_tz;
    t_lane_coef              w_coef_x, w_coef_y, w_coef_z;

    logic signed [COORD_WIDTH-1:0] w_val_x, w_val_y, w_val_z;
    logic                          w_clip_x, w_clip_y, w_clip_z;

    assign busy     = ~r_ready;
    assign w_accept = start & r_ready;

    // Configuration registers. The user must let writes arrive only while the pipeline is
    // empty (the block does not enforce it), so the quaternion can feed every stage directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.x <= '0;
            r_quat.y <= '0;
            r_quat.z <= '0;
            r_quat.w <= QW_RESET;
        end else if (i_cfg_we) begin
            unique case (t_qreg'(i_cfg_idx))
                QREG_X: r_quat.x <= i_cfg_data;
                QREG_Y: r_quat.y <= i_cfg_data;
                QREG_Z: r_quat.z <= i_cfg_data;
                QREG_W: r_quat.w <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The valid bit of each request travels alongside its data. The block
    // stays ready once r_ready is set after reset, since nothing downstream stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_vld   <= '0;
        end else begin
            r_ready <= 1'b1;
            r_vld   <= {r_vld[LATENCY-3:0], w_accept};
        end
    end

    qvr_tprod #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_tprod (
        .i_clk  (i_clk),
        .i_quat (r_quat),
        .i_vx   (i_vec_in_x),
        .i_vy   (i_vec_in_y),
        .i_vz   (i_vec_in_z),
        .o_tw   (w_tw),
        .o_tx   (w_tx),
        .o_ty   (w_ty),
        .o_tz   (w_tz)
    );

    // Lane weights, taken from the vector part of t * conj(q):
    //   rx = -tw*x + tx*w - ty*z + tz*y
    //   ry = -tw*y + tx*z + ty*w - tz*x
    //   rz = -tw*z - tx*y + ty*x + tz*w
    // Negation is done one bit wider so that the most negative part stays exact.
    always_comb begin
        w_coef_x.ctw = -QCOEF_W'(r_quat.x);
        w_coef_x.ctx =  QCOEF_W'(r_quat.w);
        w_coef_x.cty = -QCOEF_W'(r_quat.z);
        w_coef_x.ctz =  QCOEF_W'(r_quat.y);

        w_coef_y.ctw = -QCOEF_W'(r_quat.y);
        w_coef_y.ctx =  QCOEF_W'(r_quat.z);
        w_coef_y.cty =  QCOEF_W'(r_quat.w);
        w_coef_y.ctz = -QCOEF_W'(r_quat.x);

        w_coef_z.ctw = -QCOEF_W'(r_quat.z);
        w_coef_z.ctx = -QCOEF_W'(r_quat.y);
        w_coef_z.cty =  QCOEF_W'(r_quat.x);
        w_coef_z.ctz =  QCOEF_W'(r_quat.w);
    end

    qvr_lane #(
        .COORD_WIDTH    (COORD_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_lane_x (
        .i_clk  (i_clk),
        .i_coef (w_coef_x),
        .i_tw   (w_tw),
        .i_tx   (w_tx),
        .i_ty   (w_ty),
        .i_tz   (w_tz),
        .o_val  (w_val_x),
        .o_clip (w_clip_x)
    );

    qvr_lane #(
        .COORD_WIDTH    (COORD_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_lane_y (
        .i_clk  (i_clk),
        .i_coef (w_coef_y),
        .i_tw   (w_tw),
        .i_tx   (w_tx),
        .i_ty   (w_ty),
        .i_tz   (w_tz),
        .o_val  (w_val_y),
        .o_clip (w_clip_y)
    );

    qvr_lane #(
        .COORD_WIDTH    (COORD_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_lane_z (
        .i_clk  (i_clk),
        .i_coef (w_coef_z),
        .i_tw   (w_tw),
        .i_tx   (w_tx),
        .i_ty   (w_ty),
        .i_tz   (w_tz),
        .o_val  (w_val_z),
        .o_clip (w_clip_z)
    );

    qvr_merge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (r_vld[LATENCY-2]),
        .i_x       (w_val_x),
        .i_y       (w_val_y),
        .i_z       (w_val_z),
        .i_clip_x  (w_clip_x),
        .i_clip_y  (w_clip_y),
        .i_clip_z  (w_clip_z),
        .o_valid   (o_valid),
        .o_x       (o_vec_out_x),
        .o_y       (o_vec_out_y),
        .o_z       (o_vec_out_z),
        .o_clipped (o_clipped)
    );

endmodule

`default_nettype wire

// ===== rtl/qvr_checker.sv =====
// Port-level checks for the quaternion vector rotator, and the bind that attaches them.
// Depends on qvr_pkg and on the top level quaternion_vector_rotate.
`timescale 1ns / 1ps
`default_nettype none

module qvr_checker
    import qvr_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_start,
    input wire                      i_busy,
    input wire                      i_valid,
    input wire [COORD_WIDTH-1:0]    i_out_x,
    input wire [COORD_WIDTH-1:0]    i_out_y,
    input wire [COORD_WIDTH-1:0]    i_out_z,
    input wire                      i_clipped
);

    localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

    // Every accepted request produces its result after the fixed latency.
    a_req_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |-> ##LATENCY i_valid)
        else $error("accepted request produced no result");

    // No result appears without a request accepted the fixed latency earlier.
    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> $past(i_start && !i_busy, LATENCY))
        else $error("result without a matching request");

    // A clipped result has at least one component at a range limit.
    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_clipped) |->
            (i_out_x == C_MAX || i_out_x == C_MIN ||
             i_out_y == C_MAX || i_out_y == C_MIN ||
             i_out_z == C_MAX || i_out_z == C_MIN))
        else $error("clipped flag without a saturated component");

    // Reset empties the pipeline and blocks new requests.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_valid && i_busy))
        else $error("reset did not flush the pipeline");

endmodule

bind quaternion_vector_rotate qvr_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_qvr_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (start),
    .i_busy    (busy),
    .i_valid   (o_valid),
    .i_out_x   (o_vec_out_x),
    .i_out_y   (o_vec_out_y),
    .i_out_z   (o_vec_out_z),
    .i_clipped (o_clipped)
);

`default_nettype wire

// ===== tb/tb_quaternion_vector_rotate.sv =====
// Self-checking testbench for the quaternion vector rotator.
// Needs qvr_pkg and quaternion_vector_rotate from rtl/, with the modules that the top level instantiates.
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate;
    import qvr_pkg::*;

    localparam int COORD_WIDTH    = 16;
    localparam int QUAT_FRAC_BITS = 14;
    // Far above the length of the slowest correct run.
    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_PRINTED    = 40;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    // One predicted rotation result.
    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   clip;
    } t_rotation;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    t_coord                 i_vec_in_x;
    t_coord                 i_vec_in_y;
    t_coord                 i_vec_in_z;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [QUAT_W-1:0]      i_cfg_data;
    logic                   o_valid;
    t_coord                 o_vec_out_x;
    t_coord                 o_vec_out_y;
    t_coord                 o_vec_out_z;
    logic                   o_clipped;

    quaternion_vector_rotate #(
        .COORD_WIDTH    (COORD_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_vec_in_x  (i_vec_in_x),
        .i_vec_in_y  (i_vec_in_y),
        .i_vec_in_z  (i_vec_in_z),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_vec_out_x (o_vec_out_x),
        .o_vec_out_y (o_vec_out_y),
        .o_vec_out_z (o_vec_out_z),
        .o_clipped   (o_clipped)
    );

    // The testbench's own copy of the quaternion registers, updated on each write.
    t_quat     quat_shadow;
    // Rotations predicted for accepted requests, oldest first.
    t_rotation pending_rotations[$];

    int sender_idle_pct;
    int mismatch_count;
    int requests_sent;
    int rotations_checked;
    int quat_writes;
    int clipped_seen;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d rotations still pending",
                     cycle_count, pending_rotations.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Prints one mismatch line (up to a cap) and counts every one.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Rounds a sum scaled by 2^(2*QUAT_FRAC_BITS) to nearest (ties toward plus
    // infinity) and clamps it to the coordinate range, raising clip when it clamps.
    function automatic t_coord round_and_clamp(input longint scaled, inout logic clip);
        longint maxv;
        longint minv;
        longint rounded;
        maxv    = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        minv    = -maxv - 1;
        rounded = (scaled + (longint'(1) <<< (2 * QUAT_FRAC_BITS - 1)))
                  >>> (2 * QUAT_FRAC_BITS);
        if (rounded > maxv) begin
            rounded = maxv;
            clip    = 1'b1;
        end
        if (rounded < minv) begin
            rounded = minv;
            clip    = 1'b1;
        end
        return t_coord'(rounded);
    endfunction

    // Computes q * (v, 0) * conj(q) exactly in 64-bit arithmetic and keeps the vector part.
    function automatic t_rotation rotate_vector(input t_quat q, input t_coord vx,
                                                input t_coord vy, input t_coord vz);
        longint qx, qy, qz, qw;
        longint ax, ay, az;
        longint tx, ty, tz, tw;
        t_rotation r;
        qx = q.x;
        qy = q.y;
        qz = q.z;
        qw = q.w;
        ax = vx;
        ay = vy;
        az = vz;
        // First Hamilton product: the pure quaternion of the vector on the right.
        tx = qw * ax + qy * az - qz * ay;
        ty = qw * ay - qx * az + qz * ax;
        tz = qw * az + qx * ay - qy * ax;
        tw = -(qx * ax) - qy * ay - qz * az;
        // Second product with the conjugate; the scalar part is dropped.
        r.clip = 1'b0;
        r.x = round_and_clamp(-(tw * qx) + tx * qw - ty * qz + tz * qy, r.clip);
        r.y = round_and_clamp(-(tw * qy) + tx * qz + ty * qw - tz * qx, r.clip);
        r.z = round_and_clamp(-(tw * qz) - tx * qy + ty * qx + tz * qw, r.clip);
        return r;
    endfunction

    // Every result strobe is compared with the oldest pending prediction.
    always @(posedge i_clk) begin
        t_rotation want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_rotations.size() == 0) begin
                report_mismatch($sformatf("result (%0d,%0d,%0d) with no request pending",
                                          o_vec_out_x, o_vec_out_y, o_vec_out_z));
            end else begin
                want = pending_rotations.pop_front();
                rotations_checked++;
                if (want.clip)
                    clipped_seen++;
                if (o_vec_out_x !== want.x)
                    report_mismatch($sformatf("x got %0d expected %0d", o_vec_out_x, want.x));
                if (o_vec_out_y !== want.y)
                    report_mismatch($sformatf("y got %0d expected %0d", o_vec_out_y, want.y));
                if (o_vec_out_z !== want.z)
                    report_mismatch($sformatf("z got %0d expected %0d", o_vec_out_z, want.z));
                if (o_clipped !== want.clip)
                    report_mismatch($sformatf("clipped got %0b expected %0b",
                                              o_clipped, want.clip));
            end
        end
    end

    // Sends one request. Called just after a falling edge and returns just after one.
    // Start is left high on return, so back-to-back requests keep it high without a gap.
    task automatic send_vector(input t_coord vx, input t_coord vy, input t_coord vz);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_vec_in_x <= vx;
        i_vec_in_y <= vy;
        i_vec_in_z <= vz;
        // Busy only moves on a rising edge, so its value here is the one the edge sees.
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        pending_rotations.push_back(rotate_vector(quat_shadow, vx, vy, vz));
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Stops sending, waits until every pending rotation has come back and then waits out
    // the pipeline, so that the block is idle before the quaternion changes.
    task automatic drain_rotations();
        start <= 1'b0;
        while (pending_rotations.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    // Writes all four quaternion registers, one per cycle. Only called when idle.
    task automatic set_quaternion(input t_quat q);
        t_qreg order[4] = '{QREG_X, QREG_Y, QREG_Z, QREG_W};
        logic [QUAT_W-1:0] value;
        foreach (order[k]) begin
            case (order[k])
                QREG_X: value = q.x;
                QREG_Y: value = q.y;
                QREG_Z: value = q.z;
                default: value = q.w;
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= order[k];
            i_cfg_data <= value;
            @(posedge i_clk);
            case (order[k])
                QREG_X: quat_shadow.x = value;
                QREG_Y: quat_shadow.y = value;
                QREG_Z: quat_shadow.z = value;
                default: quat_shadow.w = value;
            endcase
            quat_writes++;
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_quat make_quat(input int x, input int y, input int z, input int w);
        t_quat q;
        q.x = QUAT_W'(x);
        q.y = QUAT_W'(y);
        q.z = QUAT_W'(z);
        q.w = QUAT_W'(w);
        return q;
    endfunction

    // One quaternion part: full range, moderate (at most 9000 in magnitude), or a special value such as a limit.
    function automatic logic [QUAT_W-1:0] random_quat_part(input int kind);
        case (kind)
            0: return QUAT_W'($urandom_range(0, 65535));
            1: return QUAT_W'(int'($urandom_range(0, 18000)) - 9000);
            default: begin
                case ($urandom_range(0, 5))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    3: return QW_RESET;
                    4: return -QW_RESET;
                    default: return 16'hffff;
                endcase
            end
        endcase
    endfunction

    function automatic t_quat random_quaternion();
        t_quat q;
        int kind;
        case ($urandom_range(0, 3))
            0: kind = 0;
            3: kind = 2;
            default: kind = 1;
        endcase
        q.x = random_quat_part(kind);
        q.y = random_quat_part(kind);
        q.z = random_quat_part(kind);
        q.w = random_quat_part(kind);
        return q;
    endfunction

    function automatic t_coord random_coord();
        if ($urandom_range(0, 4) != 0)
            return t_coord'($urandom);
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    // The reset value of the registers must be the identity, so vectors come back unchanged.
    task automatic test_identity_after_reset();
        send_vector(32767, -32768, 0);
        send_vector(-32768, 32767, 1);
        send_vector(-1, 1, -1);
        drain_rotations();
    endtask

    // A half-scale quaternion quarters the vector and makes exact halves, which must round toward plus infinity.
    task automatic test_rounding_halfway();
        set_quaternion(make_quat(0, 0, 0, 8192));
        send_vector(2, -2, 6);
        send_vector(-6, 1, -1);
        drain_rotations();
    endtask

    // Plain rotations: a quarter turn about z and a half turn about x.
    task automatic test_axis_rotations();
        set_quaternion(make_quat(0, 0, 11585, 11585));
        send_vector(1000, 0, 0);
        send_vector(12345, -23456, 32767);
        drain_rotations();
        set_quaternion(make_quat(16384, 0, 0, 0));
        send_vector(100, -200, 300);
        drain_rotations();
    endtask

    // Quaternions at the register limits scale the vector hard, so large vectors must saturate.
    task automatic test_saturation_extremes();
        set_quaternion(make_quat(-32768, -32768, -32768, -32768));
        send_vector(32767, 32767, 32767);
        send_vector(-32768, -32768, -32768);
        send_vector(1, 0, 0);
        drain_rotations();
        set_quaternion(make_quat(32767, 32767, 32767, 32767));
        send_vector(100, -200, 300);
        send_vector(32767, -32768, 32767);
        drain_rotations();
        set_quaternion(make_quat(0, 0, 0, -32768));
        send_vector(8191, -8192, 8192);
        drain_rotations();
        // A zero quaternion flattens everything to zero.
        set_quaternion(make_quat(0, 0, 0, 0));
        send_vector(32767, -32768, 12345);
        drain_rotations();
    endtask

    // Bursts of random vectors, each under a fresh random quaternion. The sender
    // pauses until all results are back before every quaternion change.
    task automatic test_random_stream(input int idle_pct, input int count);
        int left;
        int burst;
        sender_idle_pct = idle_pct;
        left = count;
        while (left > 0) begin
            drain_rotations();
            set_quaternion(random_quaternion());
            burst = $urandom_range(20, 60);
            if (burst > left)
                burst = left;
            repeat (burst) send_vector(random_coord(), random_coord(), random_coord());
            left -= burst;
        end
        drain_rotations();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_vec_in_x        = '0;
        i_vec_in_y        = '0;
        i_vec_in_z        = '0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = QREG_X;
        i_cfg_data        = '0;
        quat_shadow       = make_quat(0, 0, 0, QW_RESET);
        sender_idle_pct   = 15;
        mismatch_count    = 0;
        requests_sent     = 0;
        rotations_checked = 0;
        quat_writes       = 0;
        clipped_seen      = 0;
        cycle_count       = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Busy stays high after reset is released until the block sets ready; wait for it to drop before anything else.
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        @(negedge i_clk);

        test_identity_after_reset();
        test_rounding_halfway();
        test_axis_rotations();
        test_saturation_extremes();
        test_random_stream(15, 645);
        test_random_stream(63, 645);
        test_random_stream(0, 645);

        // drain_rotations has already waited out the pipeline after the last request.
        $display("Sent %0d vectors under %0d quaternion register writes.",
                 requests_sent, quat_writes);
        $display("Checked %0d rotations, %0d of them saturated; %0d mismatches.",
                 rotations_checked, clipped_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== quaternion_vector_rotate.f =====
rtl/qvr_pkg.sv
rtl/qvr_tprod.sv
rtl/qvr_lane.sv
rtl/qvr_merge.sv
rtl/quaternion_vector_rotate.sv
rtl/qvr_checker.sv
tb/tb_quaternion_vector_rotate.sv
